@@ design/lrl_pkg.sv @@
// shared types and constants for the lru recency list
package lrl_pkg;

	localparam int SLOT_FIELD_W = 6;
	localparam int IN_TDATA_W   = 8;
	localparam int OUT_TDATA_W  = 16;

	localparam logic OP_TOUCH  = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} lrl_state_t;

	typedef struct packed {
		logic [SLOT_FIELD_W-1:0] victim_slot;
		logic [SLOT_FIELD_W-1:0] newest_slot;
		logic                    list_empty;
		logic                    was_present;
	} lrl_result_t;

endpackage

@@ design/lrl_ram.sv @@
// single-port-write, single-port-read synchronous ram with registered read-first output
module lrl_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 7
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/lru_recency_list_top.sv @@
// lru recency list: doubly linked list of slots kept in link memories
// the input is registered with the ram reads of its slot, and the result is registered to the output
// when the update commits; no new transaction is taken before that commit, since a slot's links
//   are read, then its neighbors' links are written back on the single write port
// reset: head and tail go to null, then a clearing pass over every slot zeroes the membership
//   memory while s_axis_tready stays low
module lru_recency_list_top
	import lrl_pkg::*;
#(
	parameter int SLOT_COUNT = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // slot_index[5:0], zero fill
	input  logic                   s_axis_tuser,  // opcode
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // victim_slot, newest_slot, list_empty,
	                                              // was_present, zero fill
);

	localparam int IW = $clog2(SLOT_COUNT);
	localparam int LW = IW + 1;
	localparam int CW = ((IW > SLOT_FIELD_W) ? IW : SLOT_FIELD_W) + 1;

	lrl_state_t state_q, state_d;

	logic [IW-1:0] clr_cnt_q;
	logic          clr_last;
	logic [LW-1:0] head_q, tail_q, head_d, tail_d;

	logic          op_s1;
	logic [IW-1:0] idx_s1;
	logic          slot_ok_s1;

	logic          accept;
	logic [CW-1:0] in_ext;
	logic          in_ok;
	logic [IW-1:0] in_idx;
	logic          in_hit_head;
	logic          first_re;

	logic [LW-1:0] older_rd, newer_rd;
	logic          member_rd;
	logic          older_we, newer_we, member_we;
	logic [IW-1:0] older_wa, newer_wa, member_wa;
	logic [LW-1:0] older_wd, newer_wd;
	logic          member_wd;

	logic          commit;
	logic          present;
	logic          hit_head, hit_tail;
	logic [LW-1:0] prev_l, next_l;
	logic          unlink;

	logic          out_valid_q;
	lrl_result_t   out_q, res_d;
	logic [CW-1:0] tail_ext, head_ext;

	// input decode
	assign accept      = s_axis_tvalid && s_axis_tready;
	assign in_ext      = CW'(s_axis_tdata[SLOT_FIELD_W-1:0]);
	assign in_ok       = in_ext < CW'(SLOT_COUNT);
	assign in_idx      = in_ext[IW-1:0];
	assign in_hit_head = !head_q[IW] && (head_q[IW-1:0] == in_idx);
	assign first_re    = accept && in_ok;
	assign clr_last    = clr_cnt_q == IW'(SLOT_COUNT - 1);

	// update stage decode
	assign commit   = (state_q == ST_UPDATE) && (!out_valid_q || m_axis_tready);
	assign present  = slot_ok_s1 && member_rd;
	assign hit_head = !head_q[IW] && (head_q[IW-1:0] == idx_s1);
	assign hit_tail = !tail_q[IW] && (tail_q[IW-1:0] == idx_s1);
	assign prev_l   = hit_tail ? {1'b1, IW'(0)} : older_rd;
	assign next_l   = hit_head ? {1'b1, IW'(0)} : newer_rd;
	assign unlink   = commit && present && !((op_s1 == OP_TOUCH) && hit_head);

	// memory write ports
	always_comb begin
		older_we = 1'b0;
		older_wa = in_idx;
		older_wd = head_q;
		newer_we = 1'b0;
		newer_wa = head_q[IW-1:0];
		newer_wd = {1'b0, in_idx};
		if (state_q == ST_UPDATE) begin
			older_we = unlink && !next_l[IW];
			older_wa = next_l[IW-1:0];
			older_wd = prev_l;
			newer_we = unlink && !prev_l[IW];
			newer_wa = prev_l[IW-1:0];
			newer_wd = next_l;
		end else begin
			older_we = first_re && (s_axis_tuser == OP_TOUCH) && !in_hit_head;
			newer_we = first_re && (s_axis_tuser == OP_TOUCH) && !in_hit_head && !head_q[IW];
		end
	end

	always_comb begin
		member_we = 1'b0;
		member_wa = in_idx;
		member_wd = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				member_we = 1'b1;
				member_wa = clr_cnt_q;
				member_wd = 1'b0;
			end
			ST_UPDATE: begin
				member_we = commit && present && (op_s1 == OP_REMOVE);
				member_wa = idx_s1;
				member_wd = 1'b0;
			end
			default: begin
				member_we = first_re && (s_axis_tuser == OP_TOUCH);
			end
		endcase
	end

	lrl_ram #(.DEPTH(SLOT_COUNT), .WIDTH(LW)) u_older_ram (
		.clk   (clk),
		.re    (first_re),
		.raddr (in_idx),
		.rdata (older_rd),
		.we    (older_we),
		.waddr (older_wa),
		.wdata (older_wd)
	);

	lrl_ram #(.DEPTH(SLOT_COUNT), .WIDTH(LW)) u_newer_ram (
		.clk   (clk),
		.re    (first_re),
		.raddr (in_idx),
		.rdata (newer_rd),
		.we    (newer_we),
		.waddr (newer_wa),
		.wdata (newer_wd)
	);

	lrl_ram #(.DEPTH(SLOT_COUNT), .WIDTH(1)) u_member_ram (
		.clk   (clk),
		.re    (first_re),
		.raddr (in_idx),
		.rdata (member_rd),
		.we    (member_we),
		.waddr (member_wa),
		.wdata (member_wd)
	);

	// head and tail after the operation
	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		if (slot_ok_s1) begin
			if (op_s1 == OP_TOUCH) begin
				if (!present) begin
					head_d = {1'b0, idx_s1};
					if (tail_q[IW]) begin
						tail_d = {1'b0, idx_s1};
					end
				end else if (!hit_head) begin
					head_d = {1'b0, idx_s1};
					if (hit_tail) begin
						tail_d = next_l;
					end
				end
			end else if (present) begin
				if (hit_tail) begin
					tail_d = next_l;
				end
				if (hit_head) begin
					head_d = prev_l;
				end
			end
		end
	end

	assign tail_ext = CW'(tail_d[IW-1:0]);
	assign head_ext = CW'(head_d[IW-1:0]);

	always_comb begin
		res_d.list_empty  = head_d[IW] || tail_d[IW];
		res_d.victim_slot = res_d.list_empty ? '0 : tail_ext[SLOT_FIELD_W-1:0];
		res_d.newest_slot = res_d.list_empty ? '0 : head_ext[SLOT_FIELD_W-1:0];
		res_d.was_present = present;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			head_q      <= {1'b1, IW'(0)};
			tail_q      <= {1'b1, IW'(0)};
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + IW'(1);
			end
			if (commit) begin
				head_q      <= head_d;
				tail_q      <= tail_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= s_axis_tuser;
			idx_s1     <= in_idx;
			slot_ok_s1 <= in_ok;
		end
		if (commit) begin
			out_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.was_present, out_q.list_empty,
		out_q.newest_slot, out_q.victim_slot};

endmodule

@@ verif/lrl_report_checker.sv @@
// checker for the lru recency list: predicts each report and compares it on the output stream
module lrl_report_checker
	import lrl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tuser,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output int                     fail_count,
	output int                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         SLOTS   = 64;
	localparam logic [6:0] NO_SLOT = 7'd64;

	logic [6:0]  older_of [SLOTS];
	logic [6:0]  newer_of [SLOTS];
	logic        member [SLOTS];
	logic [6:0]  head_slot;
	logic [6:0]  tail_slot;
	lrl_result_t expected_reports [$];
	int          bad_reports;

	task automatic detach_slot(input logic [5:0] s);
		logic [6:0] p;
		logic [6:0] n;
		p = older_of[s];
		n = newer_of[s];
		if (p != NO_SLOT) begin
			newer_of[p[5:0]] = n;
		end
		if (n != NO_SLOT) begin
			older_of[n[5:0]] = p;
		end
		if (tail_slot == {1'b0, s}) begin
			tail_slot = n;
		end
		if (head_slot == {1'b0, s}) begin
			head_slot = p;
		end
		older_of[s] = NO_SLOT;
		newer_of[s] = NO_SLOT;
		member[s]   = 1'b0;
	endtask

	task automatic apply_recency_op(input logic op, input logic [5:0] s, output lrl_result_t rep);
		logic present;
		logic empty;
		present = member[s];
		if (present) begin
			detach_slot(s);
		end
		if (op == OP_TOUCH) begin
			// append as most recent
			older_of[s] = head_slot;
			newer_of[s] = NO_SLOT;
			if (head_slot != NO_SLOT) begin
				newer_of[head_slot[5:0]] = {1'b0, s};
			end
			head_slot = {1'b0, s};
			if (tail_slot == NO_SLOT) begin
				tail_slot = {1'b0, s};
			end
			member[s] = 1'b1;
		end
		empty = (head_slot == NO_SLOT) || (tail_slot == NO_SLOT);
		rep.victim_slot = empty ? '0 : tail_slot[5:0];
		rep.newest_slot = empty ? '0 : head_slot[5:0];
		rep.list_empty  = empty;
		rep.was_present = present;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lrl_result_t want;
		lrl_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				older_of[i] = NO_SLOT;
				newer_of[i] = NO_SLOT;
				member[i]   = 1'b0;
			end
			head_slot = NO_SLOT;
			tail_slot = NO_SLOT;
			expected_reports.delete();
			bad_reports = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.victim_slot = m_axis_tdata[5:0];
				got.newest_slot = m_axis_tdata[11:6];
				got.list_empty  = m_axis_tdata[12];
				got.was_present = m_axis_tdata[13];
				if (expected_reports.size() == 0) begin
					bad_reports++;
					if (bad_reports <= 10) begin
						$display("unexpected report: victim %0d newest %0d empty %0b present %0b",
							got.victim_slot, got.newest_slot, got.list_empty, got.was_present);
					end
				end else begin
					want = expected_reports.pop_front();
					if (got.victim_slot != want.victim_slot || got.newest_slot != want.newest_slot
						|| got.list_empty != want.list_empty
						|| got.was_present != want.was_present) begin
						bad_reports++;
						if (bad_reports <= 10) begin
							$display("report differs at %0t: victim %0d/%0d newest %0d/%0d %s",
								$realtime, want.victim_slot, got.victim_slot,
								want.newest_slot, got.newest_slot, "(expected/actual)");
							$display("  empty %0b/%0b present %0b/%0b",
								want.list_empty, got.list_empty,
								want.was_present, got.was_present);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				apply_recency_op(s_axis_tuser, s_axis_tdata[5:0], want);
				expected_reports.push_back(want);
			end
			fail_count  <= bad_reports;
			outstanding <= expected_reports.size();
		end
	end

endmodule

@@ verif/tb_lru_recency_list_top.sv @@
// testbench top for the lru recency list: clock, reset, stream stimulus and verdict
module tb_lru_recency_list_top
	import lrl_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	int                     fail_count;
	int                     outstanding;
	int                     sink_stall_pct;
	int                     src_gap_pct;
	int                     stall_left;
	int                     cycle_count;

	lru_recency_list_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	lrl_report_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		m_axis_tready  <= 1'b0;
		sink_stall_pct <= 0;
		stall_left     <= 0;
		cycle_count    <= 0;
	end

	// receiver stalls in bursts of random length
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (sink_stall_pct != 0 && $urandom_range(1, 100) <= sink_stall_pct) begin
			stall_left    <= $urandom_range(0, 6);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("lru_recency_list_top: mismatch");
			$finish;
		end
	end

	task automatic issue(input logic op, input logic [5:0] slot);
		s_axis_tuser  <= op;
		s_axis_tdata  <= {2'b00, slot};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		int         span;
		int         base;
		int         touch_pct;
		logic       op;
		logic [5:0] slot;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= OP_TOUCH;
		src_gap_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, touch of newest, tail and middle moves, removes down to empty
		src_gap_pct = 20;
		sink_stall_pct <= 20;
		issue(OP_REMOVE, 6'd0);
		issue(OP_TOUCH, 6'd0);
		issue(OP_TOUCH, 6'd0);
		issue(OP_TOUCH, 6'd63);
		issue(OP_TOUCH, 6'd21);
		issue(OP_TOUCH, 6'd42);
		issue(OP_TOUCH, 6'd63);
		issue(OP_TOUCH, 6'd0);
		issue(OP_TOUCH, 6'd0);
		issue(OP_REMOVE, 6'd21);
		issue(OP_REMOVE, 6'd21);
		issue(OP_TOUCH, 6'd5);
		issue(OP_TOUCH, 6'd9);
		issue(OP_REMOVE, 6'd5);
		issue(OP_REMOVE, 6'd0);
		issue(OP_REMOVE, 6'd9);
		issue(OP_REMOVE, 6'd63);
		issue(OP_REMOVE, 6'd42);
		issue(OP_REMOVE, 6'd42);
		issue(OP_TOUCH, 6'd1);
		wait_drained();

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: begin
					span = 64; touch_pct = 90; src_gap_pct = 30; sink_stall_pct <= 30;
				end
				1: begin
					span = 4; touch_pct = 50; src_gap_pct = 0; sink_stall_pct <= 0;
				end
				2: begin
					span = 8; touch_pct = 60; src_gap_pct = 20; sink_stall_pct <= 50;
				end
				3: begin
					span = 64; touch_pct = 20; src_gap_pct = 10; sink_stall_pct <= 10;
				end
				4: begin
					span = 64; touch_pct = 65; src_gap_pct = 40; sink_stall_pct <= 20;
				end
				5: begin
					span = 2; touch_pct = 50; src_gap_pct = 25; sink_stall_pct <= 25;
				end
				default: begin
					span = 64; touch_pct = 60; src_gap_pct = 0; sink_stall_pct <= 0;
				end
			endcase
			base = $urandom_range(0, 64 - span);
			for (int k = 0; k < 100; k++) begin
				op   = ($urandom_range(1, 100) <= touch_pct) ? OP_TOUCH : OP_REMOVE;
				slot = 6'(base + $urandom_range(0, span - 1));
				issue(op, slot);
			end
			if (phase == 2 || phase == 4) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("lru_recency_list_top: match");
		end else begin
			$display("lru_recency_list_top: mismatch");
		end
		$finish;
	end

endmodule
